// ===== rtl/efsc_pkg.sv =====
// ----------------------------------------------------------------------------
// efsc_pkg
// shared types and constants for the frame statistics counters
// ----------------------------------------------------------------------------
package efsc_pkg;

  localparam int CNT_COUNT = 16;
  localparam int CNT_IDX_W = 4;
  localparam int CNT_W     = 64;
  localparam int LEN_W     = 16;

  typedef logic [CNT_IDX_W-1:0] cnt_idx_t;
  typedef logic [CNT_COUNT-1:0] cnt_mask_t;
  typedef logic [CNT_W-1:0]     cnt_val_t;
  typedef logic [LEN_W-1:0]     len_t;

  // counter map
  localparam cnt_idx_t CNT_TOTAL_BYTES   = 4'd0;
  localparam cnt_idx_t CNT_SHORT         = 4'd1;
  localparam cnt_idx_t CNT_NORMAL        = 4'd2;
  localparam cnt_idx_t CNT_LONG          = 4'd3;
  localparam cnt_idx_t CNT_MAC_BCAST     = 4'd4;
  localparam cnt_idx_t CNT_ARP           = 4'd5;
  localparam cnt_idx_t CNT_IP_PKT        = 4'd6;
  localparam cnt_idx_t CNT_IP_BCAST      = 4'd7;
  localparam cnt_idx_t CNT_IP_BYTES      = 4'd8;
  localparam cnt_idx_t CNT_ICMP          = 4'd9;
  localparam cnt_idx_t CNT_ICMP_REPLY    = 4'd10;
  localparam cnt_idx_t CNT_ICMP_UNREACH  = 4'd11;
  localparam cnt_idx_t CNT_ICMP_REDIRECT = 4'd12;
  localparam cnt_idx_t CNT_ICMP_REQUEST  = 4'd13;
  localparam cnt_idx_t CNT_TCP           = 4'd14;
  localparam cnt_idx_t CNT_UDP           = 4'd15;

  // header codes
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  L4_ICMP    = 8'd1;
  localparam logic [7:0]  L4_TCP     = 8'd6;
  localparam logic [7:0]  L4_UDP     = 8'd17;
  localparam logic [7:0]  ICMP_REPLY    = 8'd0;
  localparam logic [7:0]  ICMP_UNREACH  = 8'd3;
  localparam logic [7:0]  ICMP_REDIRECT = 8'd5;
  localparam logic [7:0]  ICMP_REQUEST  = 8'd8;
  localparam logic [47:0] MAC_ALL_ONES  = 48'hffff_ffff_ffff;
  localparam logic [31:0] IP_ALL_ONES   = 32'hffff_ffff;

  // item function codes
  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // configuration register indexes
  localparam logic REG_SHORT_LIMIT = 1'b0;
  localparam logic REG_LONG_LIMIT  = 1'b1;

  localparam len_t SHORT_LIMIT_RST = 16'd64;
  localparam len_t LONG_LIMIT_RST  = 16'd1518;

  // one read-modify-write operation on the counter memory
  typedef struct packed {
    logic     vld;
    logic     rd;
    cnt_idx_t idx;
    len_t     amt;
  } cnt_op_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic ready;
  } seq_stat_t;

  function automatic cnt_idx_t lowest_idx(input cnt_mask_t mask);
    cnt_idx_t idx;
    idx = '0;
    for (int i = CNT_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = cnt_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/ethernet_frame_statistics_counters.sv =====
// ----------------------------------------------------------------------------
// ethernet_frame_statistics_counters
// sixteen 64-bit frame statistics counters kept in one memory
// ----------------------------------------------------------------------------
// a frame word issues one counter update for each counter it touches, 1 to 8
// updates; a read word issues its single read once the output register and
// the read stage are empty, and its result goes from the read stage into the
// output register, so a read waits while an earlier result is in either one
// all counter operations go through the one read-modify-write pipeline of the memory
// a new word is taken in the cycle the previous item issues its last update
// reset clears all counters at once (per-entry written bits) and loads the
// limits with 64 and 1518
// ----------------------------------------------------------------------------
module ethernet_frame_statistics_counters import efsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic        in_frame_valid,
  input  logic [15:0] in_frame_len,
  input  logic [47:0] in_dest_mac,
  input  logic [15:0] in_ethertype,
  input  logic [31:0] in_dest_ip,
  input  logic [15:0] in_ip_total_len,
  input  logic [7:0]  in_ip_protocol,
  input  logic [7:0]  in_icmp_type,
  input  logic [3:0]  in_counter_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_counter_value,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // limit registers
  len_t short_limit_r, short_limit_nxt;
  len_t long_limit_r, long_limit_nxt;

  // output word register
  logic     out_valid_r, out_valid_nxt;
  cnt_val_t out_value_r, out_value_nxt;

  logic      in_acc;
  cnt_mask_t frame_mask;
  cnt_mask_t load_mask;
  logic      out_free;
  cnt_op_t   op;
  seq_stat_t seq_stat;
  logic      rd_pend;
  logic      rd_done;
  cnt_val_t  rd_data;

  // configuration is always accepted
  assign cfg_ready = 1'b1;

  always_comb begin
    short_limit_nxt = short_limit_r;
    long_limit_nxt  = long_limit_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SHORT_LIMIT: short_limit_nxt = cfg_data;
        REG_LONG_LIMIT:  long_limit_nxt  = cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_limit_r <= SHORT_LIMIT_RST;
      long_limit_r  <= LONG_LIMIT_RST;
    end else begin
      short_limit_r <= short_limit_nxt;
      long_limit_r  <= long_limit_nxt;
    end
  end

  // classify the frame into a counter set
  efsc_class u_class (
    .frame_valid (in_frame_valid),
    .frame_len   (in_frame_len),
    .dest_mac    (in_dest_mac),
    .ethertype   (in_ethertype),
    .dest_ip     (in_dest_ip),
    .ip_protocol (in_ip_protocol),
    .icmp_type   (in_icmp_type),
    .short_limit (short_limit_r),
    .long_limit  (long_limit_r),
    .mask        (frame_mask)
  );

  // a read word selects exactly one counter
  assign load_mask = (in_func == FUNC_READ) ? (cnt_mask_t'(1) << in_counter_index)
                                            : frame_mask;

  assign in_stall = !seq_stat.ready;
  assign in_acc   = in_valid && seq_stat.ready;

  // a read may issue only when the output register will be free for it
  assign out_free = !out_valid_r && !rd_pend;

  efsc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .load_rd   (in_func == FUNC_READ),
    .load_mask (load_mask),
    .load_flen (in_frame_len),
    .load_tlen (in_ip_total_len),
    .out_free  (out_free),
    .op        (op),
    .stat      (seq_stat)
  );

  efsc_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (op),
    .rd_pend (rd_pend),
    .rd_done (rd_done),
    .rd_data (rd_data)
  );

  // result word register, held while the receiver stalls
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (rd_done) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_counter_value = out_value_r;

  // a read operation leaves the sequencer only toward an empty output
  a_read_issue_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op.vld && op.rd) |-> (!out_valid_r && !rd_pend))
    else $error("read issued while output slot occupied");

  // a read result never lands on a word still waiting at the output
  a_read_lands_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_done |-> !out_valid_r)
    else $error("read result would overwrite pending output word");

  // an accepted item always leaves work in the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> seq_stat.busy)
    else $error("accepted item left no work in sequencer");

endmodule

// ===== rtl/efsc_class.sv =====
// ----------------------------------------------------------------------------
// efsc_class
// turns one frame's header fields into the set of counters it bumps
// ----------------------------------------------------------------------------
module efsc_class import efsc_pkg::*; (
  input  logic        frame_valid,
  input  len_t        frame_len,
  input  logic [47:0] dest_mac,
  input  logic [15:0] ethertype,
  input  logic [31:0] dest_ip,
  input  logic [7:0]  ip_protocol,
  input  logic [7:0]  icmp_type,
  input  len_t        short_limit,
  input  len_t        long_limit,
  output cnt_mask_t   mask
);

  always_comb begin
    mask = '0;
    mask[CNT_TOTAL_BYTES] = 1'b1;
    if (frame_valid) begin
      if (frame_len < short_limit) begin
        mask[CNT_SHORT] = 1'b1;
      end else if (frame_len > long_limit) begin
        mask[CNT_LONG] = 1'b1;
      end else begin
        mask[CNT_NORMAL] = 1'b1;
      end
      if (dest_mac == MAC_ALL_ONES) begin
        mask[CNT_MAC_BCAST] = 1'b1;
      end
      if (ethertype == ETYPE_ARP) begin
        mask[CNT_ARP] = 1'b1;
      end else if (ethertype == ETYPE_IPV4) begin
        mask[CNT_IP_PKT]   = 1'b1;
        mask[CNT_IP_BYTES] = 1'b1;
        if (dest_ip == IP_ALL_ONES) begin
          mask[CNT_IP_BCAST] = 1'b1;
        end
        if (ip_protocol == L4_ICMP) begin
          mask[CNT_ICMP] = 1'b1;
          case (icmp_type)
            ICMP_REPLY:    mask[CNT_ICMP_REPLY]    = 1'b1;
            ICMP_UNREACH:  mask[CNT_ICMP_UNREACH]  = 1'b1;
            ICMP_REDIRECT: mask[CNT_ICMP_REDIRECT] = 1'b1;
            ICMP_REQUEST:  mask[CNT_ICMP_REQUEST]  = 1'b1;
            default:       ;
          endcase
        end else if (ip_protocol == L4_TCP) begin
          mask[CNT_TCP] = 1'b1;
        end else if (ip_protocol == L4_UDP) begin
          mask[CNT_UDP] = 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/efsc_seq.sv =====
// ----------------------------------------------------------------------------
// efsc_seq
// holds one item and issues its counter operations one per cycle, a read only once the output side is free
// ----------------------------------------------------------------------------
module efsc_seq import efsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      load_rd,
  input  cnt_mask_t load_mask,
  input  len_t      load_flen,
  input  len_t      load_tlen,
  input  logic      out_free,
  output cnt_op_t   op,
  output seq_stat_t stat
);

  cnt_mask_t mask_r, mask_nxt;
  logic      rd_r, rd_nxt;
  len_t      flen_r, flen_nxt;
  len_t      tlen_r, tlen_nxt;
  cnt_idx_t  idx;
  logic      issue;
  logic      last;

  assign idx   = lowest_idx(mask_r);
  assign issue = (mask_r != '0) && (!rd_r || out_free);
  assign last  = (mask_r & (mask_r - cnt_mask_t'(1))) == '0;

  always_comb begin
    op.vld = issue;
    op.rd  = rd_r;
    op.idx = idx;
    if (idx == CNT_TOTAL_BYTES) begin
      op.amt = flen_r;
    end else if (idx == CNT_IP_BYTES) begin
      op.amt = tlen_r;
    end else begin
      op.amt = len_t'(1);
    end
  end

  // ready when empty or when the last operation goes out this cycle
  assign stat.ready = (mask_r == '0) || (issue && last);
  assign stat.busy  = (mask_r != '0);

  always_comb begin
    mask_nxt = mask_r;
    rd_nxt   = rd_r;
    flen_nxt = flen_r;
    tlen_nxt = tlen_r;
    if (issue) begin
      mask_nxt = mask_r & ~(cnt_mask_t'(1) << idx);
    end
    if (load) begin
      mask_nxt = load_mask;
      rd_nxt   = load_rd;
      flen_nxt = load_flen;
      tlen_nxt = load_tlen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      rd_r   <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      rd_r   <= rd_nxt;
    end
    flen_r <= flen_nxt;
    tlen_r <= tlen_nxt;
  end

endmodule

// ===== rtl/efsc_bank.sv =====
// ----------------------------------------------------------------------------
// efsc_bank
// counter memory with a two-stage read-modify-write and write forwarding
// ----------------------------------------------------------------------------
module efsc_bank import efsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cnt_op_t  op,
  output logic     rd_pend,
  output logic     rd_done,
  output cnt_val_t rd_data
);

  cnt_val_t  mem [CNT_COUNT];
  cnt_mask_t written_r;

  logic     s1_vld_r, s1_rd_r;
  cnt_idx_t s1_idx_r;
  len_t     s1_amt_r;
  cnt_val_t mem_q_r;
  logic     fwd_r;
  cnt_val_t fwd_data_r;
  cnt_val_t cur;
  cnt_val_t sum;
  logic     wr_en;

  assign cur   = fwd_r ? fwd_data_r : mem_q_r;
  assign sum   = cur + cnt_val_t'(s1_amt_r);
  assign wr_en = s1_vld_r && !s1_rd_r;

  assign rd_pend = s1_vld_r && s1_rd_r;
  assign rd_done = s1_vld_r && s1_rd_r;
  assign rd_data = cur;

  // read port, never-written entries read as zero
  always_ff @(posedge clk) begin
    mem_q_r    <= written_r[op.idx] ? mem[op.idx] : '0;
    fwd_r      <= wr_en && (s1_idx_r == op.idx);
    fwd_data_r <= sum;
    s1_rd_r    <= op.rd;
    s1_idx_r   <= op.idx;
    s1_amt_r   <= op.amt;
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx_r] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      s1_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= op.vld;
      if (wr_en) begin
        written_r[s1_idx_r] <= 1'b1;
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ethernet frame statistics counters
// ----------------------------------------------------------------------------
// frame words and counter read words go in through the stall handshake. A
// shadow copy of the counter bank is updated on every accepted frame word and
// the shadow limits on every limit write. Each read word queues the counter
// value it must return, and every result word is compared against the head
// of that queue. Both ends idle at random, and one phase holds the result
// side off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import efsc_pkg::*;

  localparam int SETTLE_CYCLES   = 16;   // worst frame update plus read latency
  localparam int PRESSURE_CYCLES = 300;  // long hold on the result side
  localparam int RANDOM_WORDS    = 850;

  // one input word as the bench sees it
  typedef struct {
    logic        func;
    logic        frame_valid;
    len_t        frame_len;
    logic [47:0] dest_mac;
    logic [15:0] ethertype;
    logic [31:0] dest_ip;
    len_t        ip_total_len;
    logic [7:0]  ip_protocol;
    logic [7:0]  icmp_type;
    cnt_idx_t    counter_index;
  } stat_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = FUNC_FRAME;
  logic        in_frame_valid = 1'b0;
  logic [15:0] in_frame_len = '0;
  logic [47:0] in_dest_mac = '0;
  logic [15:0] in_ethertype = '0;
  logic [31:0] in_dest_ip = '0;
  logic [15:0] in_ip_total_len = '0;
  logic [7:0]  in_ip_protocol = '0;
  logic [7:0]  in_icmp_type = '0;
  logic [3:0]  in_counter_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_counter_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_SHORT_LIMIT;
  logic [15:0] cfg_data = '0;

  // shadow state of the block
  cnt_val_t shadow_counts [CNT_COUNT];
  len_t     shadow_short_limit;
  len_t     shadow_long_limit;

  // counter values still owed by the block, oldest first
  cnt_val_t expected_counts_q [$];

  int   error_count = 0;
  logic tx_idle_en = 1'b1;   // sender inserts gaps
  logic rx_idle_en = 1'b1;   // receiver stalls at random
  logic rx_hold_req = 1'b0;  // ask for one long receiver hold
  int   rx_hold_left = 0;

  always #5 clk = ~clk;

  ethernet_frame_statistics_counters dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_frame_valid    (in_frame_valid),
    .in_frame_len      (in_frame_len),
    .in_dest_mac       (in_dest_mac),
    .in_ethertype      (in_ethertype),
    .in_dest_ip        (in_dest_ip),
    .in_ip_total_len   (in_ip_total_len),
    .in_ip_protocol    (in_ip_protocol),
    .in_icmp_type      (in_icmp_type),
    .in_counter_index  (in_counter_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_counter_value (out_counter_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // --------------------------------------------------------------------------
  // shadow counter bank
  // --------------------------------------------------------------------------

  // apply one accepted frame word to the shadow bank, wrapping at 64 bits
  function automatic void update_counters(input stat_word_t w);
    shadow_counts[CNT_TOTAL_BYTES] += cnt_val_t'(w.frame_len);
    // a bad frame only adds its length
    if (!w.frame_valid) begin
      return;
    end
    // short wins when the limits cross
    if (w.frame_len < shadow_short_limit) begin
      shadow_counts[CNT_SHORT] += 1;
    end else if (w.frame_len > shadow_long_limit) begin
      shadow_counts[CNT_LONG] += 1;
    end else begin
      shadow_counts[CNT_NORMAL] += 1;
    end
    if (w.dest_mac == MAC_ALL_ONES) begin
      shadow_counts[CNT_MAC_BCAST] += 1;
    end
    if (w.ethertype == ETYPE_ARP) begin
      shadow_counts[CNT_ARP] += 1;
    end else if (w.ethertype == ETYPE_IPV4) begin
      shadow_counts[CNT_IP_PKT] += 1;
      shadow_counts[CNT_IP_BYTES] += cnt_val_t'(w.ip_total_len);
      if (w.dest_ip == IP_ALL_ONES) begin
        shadow_counts[CNT_IP_BCAST] += 1;
      end
      case (w.ip_protocol)
        L4_ICMP: begin
          shadow_counts[CNT_ICMP] += 1;
          case (w.icmp_type)
            ICMP_REPLY:    shadow_counts[CNT_ICMP_REPLY] += 1;
            ICMP_UNREACH:  shadow_counts[CNT_ICMP_UNREACH] += 1;
            ICMP_REDIRECT: shadow_counts[CNT_ICMP_REDIRECT] += 1;
            ICMP_REQUEST:  shadow_counts[CNT_ICMP_REQUEST] += 1;
            default: ;
          endcase
        end
        L4_TCP: shadow_counts[CNT_TCP] += 1;
        L4_UDP: shadow_counts[CNT_UDP] += 1;
        default: ;
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // word builders
  // --------------------------------------------------------------------------

  function automatic stat_word_t make_frame(input logic vld, input len_t flen,
                                            input logic [47:0] mac,
                                            input logic [15:0] etype,
                                            input logic [31:0] dip,
                                            input len_t tlen,
                                            input logic [7:0] proto,
                                            input logic [7:0] itype);
    stat_word_t w;
    w.func          = FUNC_FRAME;
    w.frame_valid   = vld;
    w.frame_len     = flen;
    w.dest_mac      = mac;
    w.ethertype     = etype;
    w.dest_ip       = dip;
    w.ip_total_len  = tlen;
    w.ip_protocol   = proto;
    w.icmp_type     = itype;
    w.counter_index = cnt_idx_t'($urandom);
    return w;
  endfunction

  // mostly well-formed ipv4 traffic, lengths clustered on the limits
  function automatic stat_word_t rand_frame();
    stat_word_t w;
    int r;
    w.func          = FUNC_FRAME;
    w.frame_valid   = ($urandom_range(0, 9) != 0);
    r = $urandom_range(0, 9);
    if (r < 3) begin
      w.frame_len = shadow_short_limit - 16'd1 + len_t'($urandom_range(0, 2));
    end else if (r < 6) begin
      w.frame_len = shadow_long_limit - 16'd1 + len_t'($urandom_range(0, 2));
    end else if (r < 8) begin
      w.frame_len = len_t'($urandom_range(0, 2047));
    end else begin
      w.frame_len = len_t'($urandom);
    end
    w.dest_mac = ($urandom_range(0, 7) == 0) ? MAC_ALL_ONES
                                             : 48'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 65) begin
      w.ethertype = ETYPE_IPV4;
    end else if (r < 80) begin
      w.ethertype = ETYPE_ARP;
    end else begin
      w.ethertype = 16'($urandom);
    end
    w.dest_ip      = ($urandom_range(0, 7) == 0) ? IP_ALL_ONES : 32'($urandom);
    w.ip_total_len = len_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 30) begin
      w.ip_protocol = L4_ICMP;
    end else if (r < 55) begin
      w.ip_protocol = L4_TCP;
    end else if (r < 80) begin
      w.ip_protocol = L4_UDP;
    end else begin
      w.ip_protocol = 8'($urandom);
    end
    case ($urandom_range(0, 5))
      0:       w.icmp_type = ICMP_REPLY;
      1:       w.icmp_type = ICMP_UNREACH;
      2:       w.icmp_type = ICMP_REDIRECT;
      3:       w.icmp_type = ICMP_REQUEST;
      default: w.icmp_type = 8'($urandom);
    endcase
    w.counter_index = cnt_idx_t'($urandom);
    return w;
  endfunction

  // read word with junk in the ignored frame fields
  function automatic stat_word_t rand_read(input cnt_idx_t idx);
    stat_word_t w;
    w = rand_frame();
    w.func = FUNC_READ;
    w.counter_index = idx;
    return w;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!tx_idle_en) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // shared driving tasks, always entered and left on a rising edge
  // --------------------------------------------------------------------------

  // offer one word and wait for it to be taken; valid stays high afterwards
  task automatic send_word(input stat_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= w.func;
    in_frame_valid   <= w.frame_valid;
    in_frame_len     <= w.frame_len;
    in_dest_mac      <= w.dest_mac;
    in_ethertype     <= w.ethertype;
    in_dest_ip       <= w.dest_ip;
    in_ip_total_len  <= w.ip_total_len;
    in_ip_protocol   <= w.ip_protocol;
    in_icmp_type     <= w.icmp_type;
    in_counter_index <= w.counter_index;
    // stall is stable at the falling edge before the edge that takes the word
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if (w.func == FUNC_READ) begin
      expected_counts_q.push_back(shadow_counts[w.counter_index]);
    end else begin
      update_counters(w);
    end
  endtask

  // stop offering, let every owed result out, then let the last frame finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_counts_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both limit registers back to back, block idle
  task automatic set_limits(input len_t short_lim, input len_t long_lim);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_SHORT_LIMIT;
    cfg_data  <= short_lim;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    shadow_short_limit = short_lim;
    cfg_index <= REG_LONG_LIMIT;
    cfg_data  <= long_lim;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    shadow_long_limit = long_lim;
    cfg_valid <= 1'b0;
  endtask

  task automatic read_all_counters();
    for (int i = 0; i < CNT_COUNT; i++) begin
      send_word(rand_read(cnt_idx_t'(i)));
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // field extremes, each protocol and icmp type, bad frame, odd ethertype
  task automatic test_directed_frames();
    send_word(make_frame(1'b1, 16'd0, MAC_ALL_ONES, ETYPE_IPV4, IP_ALL_ONES,
                         16'hffff, L4_ICMP, ICMP_REPLY));
    send_word(make_frame(1'b1, 16'd63, 48'hffff_ffff_fffe, ETYPE_IPV4,
                         32'hffff_fffe, 16'd0, L4_ICMP, ICMP_UNREACH));
    send_word(make_frame(1'b1, 16'd64, 48'h0, ETYPE_ARP, 32'h0, 16'd0,
                         8'hff, 8'hff));
    send_word(make_frame(1'b1, 16'd1518, 48'h0100_5e00_0001, ETYPE_IPV4,
                         32'hc0a8_0001, 16'd1500, L4_ICMP, ICMP_REDIRECT));
    send_word(make_frame(1'b1, 16'd1519, 48'h7fff_ffff_ffff, ETYPE_IPV4,
                         32'h7fff_ffff, 16'd1505, L4_ICMP, ICMP_REQUEST));
    send_word(make_frame(1'b1, 16'hffff, 48'h0, ETYPE_IPV4, 32'h0,
                         16'h8000, L4_ICMP, 8'hff));
    send_word(make_frame(1'b1, 16'd100, 48'h1234_5678_9abc, ETYPE_IPV4,
                         32'h0a00_0001, 16'd86, L4_TCP, ICMP_REQUEST));
    send_word(make_frame(1'b1, 16'd200, 48'h1234_5678_9abc, ETYPE_IPV4,
                         32'h0a00_0002, 16'd186, L4_UDP, ICMP_REPLY));
    send_word(make_frame(1'b1, 16'd300, 48'h1234_5678_9abc, ETYPE_IPV4,
                         32'h0a00_0003, 16'd286, 8'hff, 8'h0));
    // bad frame that would count as a broadcast icmp reply if it were good
    send_word(make_frame(1'b0, 16'hffff, MAC_ALL_ONES, ETYPE_IPV4, IP_ALL_ONES,
                         16'hffff, L4_ICMP, ICMP_REPLY));
    send_word(make_frame(1'b1, 16'd500, 48'h0, 16'hffff, IP_ALL_ONES,
                         16'hffff, L4_TCP, 8'h0));
    read_all_counters();
  endtask

  // limit registers at the extremes, crossed, and random
  task automatic test_frame_limits();
    len_t short_set [6];
    len_t long_set [6];
    short_set = '{16'd0, 16'hffff, 16'd0, 16'hffff, 16'd1518, len_t'($urandom)};
    long_set  = '{16'd0, 16'hffff, 16'hffff, 16'd0, 16'd64, len_t'($urandom)};
    for (int s = 0; s < 6; s++) begin
      set_limits(short_set[s], long_set[s]);
      for (int i = 0; i < 40; i++) begin
        send_word(rand_frame());
      end
      read_all_counters();
    end
    set_limits(SHORT_LIMIT_RST, LONG_LIMIT_RST);
  endtask

  // hold the result side while the sender keeps pushing reads and frames
  task automatic test_result_backpressure();
    tx_idle_en = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 50; i++) begin
      if (i % 5 == 4) begin
        send_word(rand_frame());
      end else begin
        send_word(rand_read(cnt_idx_t'($urandom)));
      end
    end
    wait_idle();
    tx_idle_en = 1'b1;
  endtask

  // long random mix, idling turned on and off per stretch
  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) begin
        case ((i / 100) % 4)
          0, 1: begin tx_idle_en = 1'b1; rx_idle_en = 1'b1; end
          2:    begin tx_idle_en = 1'b0; rx_idle_en = 1'b0; end
          default: begin tx_idle_en = 1'b0; rx_idle_en = 1'b1; end
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        send_word(rand_read(cnt_idx_t'($urandom)));
      end else begin
        send_word(rand_frame());
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    read_all_counters();
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // random stall on the result channel, plus the one long hold on request
  always @(posedge clk) begin
    int r;
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = PRESSURE_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_stall <= 1'b1;
    end else if (!rx_idle_en) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        out_stall <= 1'b0;
      end else begin
        // the first stalled cycle is this one
        rx_hold_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        out_stall <= 1'b1;
      end
    end
  end

  // a result word is taken at the next rising edge if valid and not stalled
  // at this falling edge
  always @(negedge clk) begin
    cnt_val_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts_q.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual %h",
                 $time, out_counter_value);
        error_count++;
      end else begin
        want = expected_counts_q.pop_front();
        if (out_counter_value !== want) begin
          $display("%0t: counter_value mismatch, expected %h, actual %h",
                   $time, want, out_counter_value);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < CNT_COUNT; i++) begin
      shadow_counts[i] = '0;
    end
    shadow_short_limit = SHORT_LIMIT_RST;
    shadow_long_limit  = LONG_LIMIT_RST;
    // synchronous reset held from time zero, then released
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_frame_limits();
    test_result_backpressure();
    test_random_traffic();
    wait_idle();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
